/* src/eth_vlan_ip_udp_header_classifier_unit_defines.svh */
// Assertion macros for the header classifier.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef ETH_VLAN_IP_UDP_HEADER_CLASSIFIER_UNIT_DEFINES_SVH
`define ETH_VLAN_IP_UDP_HEADER_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EVHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("header classifier check failed");

// Next-cycle implication, checked outside reset.
`define EVHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("header classifier check failed");

`endif

/* src/evhc_pkg.sv */
// Shared types and constants for the Ethernet/VLAN/IPv4/UDP header classifier.
// No dependencies.
package evhc_pkg;

    localparam int MAX_VLAN_TAGS_DEF    = 4;
    localparam int APP_HEADER_BYTES_DEF = 16;
    localparam int MAX_FRAME_BYTES_DEF  = 65535;

    localparam int ETH_HDR_BYTES = 14;
    localparam int TAG_BYTES     = 4;
    localparam int IP_HDR_BYTES  = 20;
    localparam int UDP_HDR_BYTES = 8;

    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_IGMP    = 8'd2;
    localparam logic [3:0]  IHL_BASIC     = 4'd5;

    typedef enum logic [1:0] {
        PH_ETH,
        PH_TAG,
        PH_IP,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic        skip;
        logic        no_vlan;
        logic        igmp_packet;
        logic        long_ip_header;
        logic        not_udp;
        logic        short_packet;
        logic        tag_overflow;
        logic [11:0] vlan_id;
        logic [31:0] ip_source;
        logic [7:0]  udp_offset;
        logic [7:0]  payload_offset;
    } result_t;

endpackage

/* src/eth_vlan_ip_udp_header_classifier_unit.sv */
// Top level of the Ethernet/VLAN/IPv4/UDP header classifier.
// Depends on evhc_pkg, evhc_parse_core, evhc_result_reg and the defines header.
//
// Frame bytes enter one per cycle while in_stall is low, in wire order, with
// last_byte marking the final captured byte; one classification request leaves
// per frame. Each byte is first held in an input register; when it advances,
// the parse state update and the classification run in a single pass into
// the parse registers and, for the last byte, into the output register; a
// last byte waits in the input register until the output register is free.
// in_stall rises only when a last byte waits while the output register still
// holds an untaken result, so a stream of back-to-back frames flows at one
// byte per cycle as long as out_stall stays low.
`include "eth_vlan_ip_udp_header_classifier_unit_defines.svh"

module eth_vlan_ip_udp_header_classifier_unit
    import evhc_pkg::*;
#(
    parameter int MAX_VLAN_TAGS    = MAX_VLAN_TAGS_DEF,
    parameter int APP_HEADER_BYTES = APP_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES  = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        skip,
    output logic        no_vlan,
    output logic        igmp_packet,
    output logic        long_ip_header,
    output logic        not_udp,
    output logic        short_packet,
    output logic        tag_overflow,
    output logic [11:0] vlan_id,
    output logic [31:0] ip_source,
    output logic [7:0]  udp_offset,
    output logic [7:0]  payload_offset
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_fire;
    logic       out_free;
    logic       in_take;
    result_t    core_res;
    result_t    out_res;

    // Advance stage one unless its last byte has nowhere to go
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    evhc_parse_core #(
        .MAX_VLAN_TAGS    (MAX_VLAN_TAGS),
        .APP_HEADER_BYTES (APP_HEADER_BYTES),
        .MAX_FRAME_BYTES  (MAX_FRAME_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .res       (core_res)
    );

    evhc_result_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (s1_fire && s1_last_reg),
        .d     (core_res),
        .stall (out_stall),
        .valid (out_valid),
        .free  (out_free),
        .q     (out_res)
    );

    assign skip           = out_res.skip;
    assign no_vlan        = out_res.no_vlan;
    assign igmp_packet    = out_res.igmp_packet;
    assign long_ip_header = out_res.long_ip_header;
    assign not_udp        = out_res.not_udp;
    assign short_packet   = out_res.short_packet;
    assign tag_overflow   = out_res.tag_overflow;
    assign vlan_id        = out_res.vlan_id;
    assign ip_source      = out_res.ip_source;
    assign udp_offset     = out_res.udp_offset;
    assign payload_offset = out_res.payload_offset;

    `EVHC_ASSERT_NEXT(a_last_gives_result, s1_fire && s1_last_reg, out_valid)
    `EVHC_ASSERT_IMP(a_stall_needs_full_out, in_stall, s1_valid_reg && s1_last_reg && out_valid)
    `EVHC_ASSERT_IMP(a_ip_flags_exclusive, out_valid, !(igmp_packet && long_ip_header))
    `EVHC_ASSERT_IMP(a_short_skips, out_valid && short_packet, skip)
    `EVHC_ASSERT_IMP(a_overflow_alone, out_valid && tag_overflow,
        skip && !short_packet && !no_vlan && (udp_offset == 8'd0))

endmodule

/* src/evhc_parse_core.sv */
// Per-frame parse state and classification logic.
// Depends on evhc_pkg.
module evhc_parse_core
    import evhc_pkg::*;
#(
    parameter int MAX_VLAN_TAGS    = MAX_VLAN_TAGS_DEF,
    parameter int APP_HEADER_BYTES = APP_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES  = MAX_FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    res
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int TAG_W = $clog2(MAX_VLAN_TAGS + 1);
    localparam int LEN_W = POS_W + 1;
    localparam int CMP_W = (LEN_W > 9) ? LEN_W : 9;

    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_TYPE0 = POS_W'(ETH_HDR_BYTES - 2);
    localparam logic [POS_W-1:0] POS_TYPE1 = POS_W'(ETH_HDR_BYTES - 1);
    localparam logic [TAG_W-1:0] TAG_MAX   = TAG_W'(MAX_VLAN_TAGS);
    localparam logic [CMP_W-1:0] ETH_END   = CMP_W'(ETH_HDR_BYTES);
    localparam logic [CMP_W-1:0] TAG_LEN   = CMP_W'(TAG_BYTES);
    localparam logic [CMP_W-1:0] IP_LEN    = CMP_W'(IP_HDR_BYTES);
    localparam logic [CMP_W-1:0] PAY_OFF   = CMP_W'(IP_HDR_BYTES + UDP_HDR_BYTES);
    localparam logic [CMP_W-1:0] APP_END   =
        CMP_W'(IP_HDR_BYTES + UDP_HDR_BYTES + APP_HEADER_BYTES);

    logic [POS_W-1:0] pos_reg,     pos_next;
    phase_t           phase_reg,   phase_next;
    logic [TAG_W-1:0] tag_reg,     tag_next;
    logic [7:0]       type_reg,    type_next;
    logic [3:0]       ihl_reg,     ihl_next;
    logic [7:0]       proto_reg,   proto_next;
    logic [31:0]      src_reg,     src_next;
    logic [11:0]      vlan_reg,    vlan_next;
    logic             no_vlan_reg, no_vlan_next;

    logic [CMP_W-1:0] p_ext;
    logic [CMP_W-1:0] ip_start;
    logic [CMP_W-1:0] ip_start_n;
    logic [CMP_W-1:0] len;
    logic [CMP_W-1:0] rel_full;
    logic [4:0]       rel;
    logic [15:0]      type_word;
    logic             in_tag_win;
    logic             in_ip_win;

    assign p_ext      = CMP_W'(pos_reg);
    assign ip_start   = ETH_END + (CMP_W'(tag_reg) << 2);
    assign rel_full   = p_ext - ip_start;
    assign rel        = rel_full[4:0];
    assign type_word  = {type_reg, data_byte};
    assign in_tag_win = (p_ext >= ip_start) && (p_ext < ip_start + TAG_LEN);
    assign in_ip_win  = (p_ext >= ip_start) && (p_ext < ip_start + IP_LEN);

    // Next state for one byte
    always_comb
    begin
        pos_next     = (pos_reg < POS_LAST) ? pos_reg + POS_W'(1) : pos_reg;
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        type_next    = type_reg;
        ihl_next     = ihl_reg;
        proto_next   = proto_reg;
        src_next     = src_reg;
        vlan_next    = vlan_reg;
        no_vlan_next = no_vlan_reg;
        case (phase_reg)
            PH_ETH:
            begin
                if (pos_reg == POS_TYPE0)
                begin
                    type_next = data_byte;
                end
                else if (pos_reg == POS_TYPE1)
                begin
                    type_next = data_byte;
                    if (type_word == ETH_TYPE_VLAN)
                    begin
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        phase_next   = PH_IP;
                        no_vlan_next = 1'b1;
                    end
                end
            end
            PH_TAG:
            begin
                if (in_tag_win)
                begin
                    if (rel == 5'd0 || rel == 5'd2)
                    begin
                        type_next = data_byte;
                    end
                    else if (rel == 5'd1)
                    begin
                        // keep only the outer tag's id
                        if (tag_reg == '0)
                        begin
                            vlan_next = {type_reg[3:0], data_byte};
                        end
                    end
                    else
                    begin
                        type_next = data_byte;
                        tag_next  = tag_reg + TAG_W'(1);
                        if (type_word == ETH_TYPE_VLAN)
                        begin
                            if (tag_next >= TAG_MAX)
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        else
                        begin
                            phase_next = PH_IP;
                        end
                    end
                end
            end
            PH_IP:
            begin
                if (in_ip_win)
                begin
                    if (rel == 5'd0)
                    begin
                        ihl_next = data_byte[3:0];
                    end
                    else if (rel == 5'd9)
                    begin
                        proto_next = data_byte;
                    end
                    else if (rel inside {[5'd12:5'd15]})
                    begin
                        src_next = {src_reg[23:0], data_byte};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign len        = p_ext + CMP_W'(1);
    assign ip_start_n = ETH_END + (CMP_W'(tag_next) << 2);

    // Classification from the state as it stands after this byte
    always_comb
    begin
        res         = '0;
        res.vlan_id = vlan_next;
        if (len <= ETH_END)
        begin
            res.skip         = 1'b1;
            res.short_packet = 1'b1;
            res.vlan_id      = '0;
        end
        else if (phase_next == PH_STOP)
        begin
            res.skip         = 1'b1;
            res.tag_overflow = 1'b1;
        end
        else if (phase_next == PH_TAG)
        begin
            res.skip         = 1'b1;
            res.short_packet = 1'b1;
        end
        else
        begin
            res.no_vlan = no_vlan_next;
            if (ip_start_n >= len)
            begin
                res.skip         = 1'b1;
                res.short_packet = 1'b1;
            end
            else
            begin
                res.udp_offset     = 8'(ip_start_n + IP_LEN);
                res.payload_offset = 8'(ip_start_n + PAY_OFF);
                if (ip_start_n + IP_LEN >= len)
                begin
                    res.skip         = 1'b1;
                    res.short_packet = 1'b1;
                end
                else
                begin
                    res.ip_source = src_next;
                    if (ihl_next != IHL_BASIC)
                    begin
                        res.igmp_packet    = (proto_next == PROTO_IGMP);
                        res.long_ip_header = (proto_next != PROTO_IGMP);
                        res.skip           = 1'b1;
                    end
                    if (proto_next != PROTO_UDP)
                    begin
                        res.not_udp = 1'b1;
                        res.skip    = 1'b1;
                    end
                    if (ip_start_n + APP_END >= len)
                    begin
                        res.short_packet = 1'b1;
                        res.skip         = 1'b1;
                    end
                end
            end
        end
    end

    // Return to the start state after the frame's last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_ETH;
            tag_reg     <= '0;
            type_reg    <= '0;
            ihl_reg     <= '0;
            proto_reg   <= '0;
            src_reg     <= '0;
            vlan_reg    <= '0;
            no_vlan_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                pos_reg     <= '0;
                phase_reg   <= PH_ETH;
                tag_reg     <= '0;
                type_reg    <= '0;
                ihl_reg     <= '0;
                proto_reg   <= '0;
                src_reg     <= '0;
                vlan_reg    <= '0;
                no_vlan_reg <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                tag_reg     <= tag_next;
                type_reg    <= type_next;
                ihl_reg     <= ihl_next;
                proto_reg   <= proto_next;
                src_reg     <= src_next;
                vlan_reg    <= vlan_next;
                no_vlan_reg <= no_vlan_next;
            end
        end
    end

endmodule

/* src/evhc_result_reg.sv */
// Output register for classification results, with valid/stall handshake.
// Depends on evhc_pkg.
module evhc_result_reg
    import evhc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t d,
    input  logic    stall,
    output logic    valid,
    output logic    free,
    output result_t q
);

    logic    valid_reg, valid_next;
    result_t q_reg;

    // Free when empty or when the held request leaves this cycle
    assign free  = !valid_reg || !stall;
    assign valid = valid_reg;
    assign q     = q_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= d;
        end
    end

endmodule

/* sim/evhc_frame_checker.sv */
`timescale 1ns / 1ps
// Result checker for the Ethernet/VLAN/IPv4/UDP header classifier: watches both
// channels, predicts one classification per frame and compares field by field.
// Depends on evhc_pkg.
module evhc_frame_checker
    import evhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        skip,
    input  logic        no_vlan,
    input  logic        igmp_packet,
    input  logic        long_ip_header,
    input  logic        not_udp,
    input  logic        short_packet,
    input  logic        tag_overflow,
    input  logic [11:0] vlan_id,
    input  logic [31:0] ip_source,
    input  logic [7:0]  udp_offset,
    input  logic [7:0]  payload_offset,
    output int          mismatch_count,
    output int          pending_count,
    output int          result_count
);

    result_t     expected_q[$];
    int          errs;
    int          seen;

    // parse state of the frame in flight
    int          pos;
    phase_t      phase;
    logic [2:0]  tag_cnt;
    logic [15:0] type_sh;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] src_sh;
    logic [11:0] vlan_h;
    logic        untagged;
    logic        tag_seen;
    logic        overflow;
    logic        vlan_seen;

    task automatic clear_parse();
        pos       = 0;
        phase     = PH_ETH;
        tag_cnt   = '0;
        type_sh   = '0;
        ihl       = '0;
        proto     = '0;
        src_sh    = '0;
        vlan_h    = '0;
        untagged  = 1'b0;
        tag_seen  = 1'b0;
        overflow  = 1'b0;
        vlan_seen = 1'b0;
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic l);
        int      p;
        int      ip_start;
        int      rel;
        int      len;
        result_t r;
        p        = pos;
        ip_start = ETH_HDR_BYTES + TAG_BYTES * tag_cnt;
        case (phase)
            PH_ETH:
            begin
                if (p == 12)
                    type_sh = {8'h00, b};
                else if (p == 13)
                begin
                    type_sh = {type_sh[7:0], b};
                    if (type_sh == ETH_TYPE_VLAN)
                    begin
                        phase    = PH_TAG;
                        tag_seen = 1'b1;
                    end
                    else
                    begin
                        phase    = PH_IP;
                        untagged = 1'b1;
                    end
                end
            end
            PH_TAG:
            begin
                if (p >= ip_start && p < ip_start + TAG_BYTES)
                begin
                    rel = p - ip_start;
                    if (rel == 0 || rel == 2)
                        type_sh = {8'h00, b};
                    else if (rel == 1)
                    begin
                        // keep the outer tag's id only
                        if (tag_cnt == 0)
                        begin
                            vlan_h    = {type_sh[3:0], b};
                            vlan_seen = 1'b1;
                        end
                    end
                    else
                    begin
                        type_sh = {type_sh[7:0], b};
                        tag_cnt = tag_cnt + 3'd1;
                        if (type_sh == ETH_TYPE_VLAN)
                        begin
                            if (tag_cnt >= MAX_VLAN_TAGS_DEF)
                            begin
                                overflow = 1'b1;
                                phase    = PH_STOP;
                            end
                        end
                        else
                            phase = PH_IP;
                    end
                end
            end
            PH_IP:
            begin
                if (p >= ip_start && p < ip_start + IP_HDR_BYTES)
                begin
                    rel = p - ip_start;
                    if (rel == 0)
                        ihl = b[3:0];
                    else if (rel == 9)
                        proto = b;
                    else if (rel >= 12 && rel <= 15)
                        src_sh = {src_sh[23:0], b};
                end
            end
            default:
            begin
            end
        endcase

        // saturate the position on over-long frames
        if (pos < MAX_FRAME_BYTES_DEF - 1)
            pos++;

        if (l)
        begin
            r        = '0;
            len      = p + 1;
            ip_start = ETH_HDR_BYTES + TAG_BYTES * tag_cnt;
            if (len <= ETH_HDR_BYTES)
            begin
                r.skip         = 1'b1;
                r.short_packet = 1'b1;
            end
            else if (phase == PH_STOP)
            begin
                r.skip         = 1'b1;
                r.tag_overflow = 1'b1;
                r.vlan_id      = vlan_h;
            end
            else if (phase == PH_TAG)
            begin
                r.skip         = 1'b1;
                r.short_packet = 1'b1;
                r.vlan_id      = vlan_seen ? vlan_h : 12'h000;
            end
            else
            begin
                r.vlan_id = tag_seen ? vlan_h : 12'h000;
                r.no_vlan = untagged;
                if (ip_start >= len)
                begin
                    r.skip         = 1'b1;
                    r.short_packet = 1'b1;
                end
                else
                begin
                    r.udp_offset     = 8'(ip_start + IP_HDR_BYTES);
                    r.payload_offset = 8'(ip_start + IP_HDR_BYTES + UDP_HDR_BYTES);
                    if (ip_start + IP_HDR_BYTES >= len)
                    begin
                        r.skip         = 1'b1;
                        r.short_packet = 1'b1;
                    end
                    else
                    begin
                        r.ip_source = src_sh;
                        if (ihl != IHL_BASIC)
                        begin
                            if (proto == PROTO_IGMP)
                                r.igmp_packet = 1'b1;
                            else
                                r.long_ip_header = 1'b1;
                            r.skip = 1'b1;
                        end
                        if (proto != PROTO_UDP)
                        begin
                            r.not_udp = 1'b1;
                            r.skip    = 1'b1;
                        end
                        if (ip_start + IP_HDR_BYTES + UDP_HDR_BYTES
                            + APP_HEADER_BYTES_DEF >= len)
                        begin
                            r.short_packet = 1'b1;
                            r.skip         = 1'b1;
                        end
                    end
                end
            end
            expected_q.push_back(r);
            clear_parse();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            errs++;
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic compare_result();
        result_t e;
        if (expected_q.size() == 0)
        begin
            errs++;
            $display("%0t: result expected none, got vlan_id %0h ip_source %0h skip %0b",
                     $time, vlan_id, ip_source, skip);
        end
        else
        begin
            e = expected_q.pop_front();
            seen++;
            check_field("skip", 32'(e.skip), 32'(skip));
            check_field("no_vlan", 32'(e.no_vlan), 32'(no_vlan));
            check_field("igmp_packet", 32'(e.igmp_packet), 32'(igmp_packet));
            check_field("long_ip_header", 32'(e.long_ip_header), 32'(long_ip_header));
            check_field("not_udp", 32'(e.not_udp), 32'(not_udp));
            check_field("short_packet", 32'(e.short_packet), 32'(short_packet));
            check_field("tag_overflow", 32'(e.tag_overflow), 32'(tag_overflow));
            check_field("vlan_id", 32'(e.vlan_id), 32'(vlan_id));
            check_field("ip_source", e.ip_source, ip_source);
            check_field("udp_offset", 32'(e.udp_offset), 32'(udp_offset));
            check_field("payload_offset", 32'(e.payload_offset), 32'(payload_offset));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_q.delete();
            errs            = 0;
            seen            = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
            result_count   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall)
                classify_byte(data_byte, last_byte);
            mismatch_count <= errs;
            pending_count  <= expected_q.size();
            result_count   <= seen;
        end
    end

endmodule

/* sim/eth_vlan_ip_udp_header_classifier_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the header classifier: builds directed and random frames,
// drives them byte by byte with random gaps and output stalls, gives the verdict.
// Depends on evhc_pkg, the classifier RTL and evhc_frame_checker.
module eth_vlan_ip_udp_header_classifier_unit_tb
    import evhc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BYTES = 300;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        skip;
    logic        no_vlan;
    logic        igmp_packet;
    logic        long_ip_header;
    logic        not_udp;
    logic        short_packet;
    logic        tag_overflow;
    logic [11:0] vlan_id;
    logic [31:0] ip_source;
    logic [7:0]  udp_offset;
    logic [7:0]  payload_offset;

    int          mismatches;
    int          pending;
    int          results;
    int          cycle_count = 0;
    int          stall_left  = 0;
    int          idle_mode   = 0;
    int          bytes_sent  = 0;
    int          frames_sent = 0;
    logic [7:0]  frame_bytes[$];

    eth_vlan_ip_udp_header_classifier_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .skip(skip), .no_vlan(no_vlan), .igmp_packet(igmp_packet),
        .long_ip_header(long_ip_header), .not_udp(not_udp),
        .short_packet(short_packet), .tag_overflow(tag_overflow),
        .vlan_id(vlan_id), .ip_source(ip_source),
        .udp_offset(udp_offset), .payload_offset(payload_offset)
    );

    evhc_frame_checker u_frame_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .skip(skip), .no_vlan(no_vlan), .igmp_packet(igmp_packet),
        .long_ip_header(long_ip_header), .not_udp(not_udp),
        .short_packet(short_packet), .tag_overflow(tag_overflow),
        .vlan_id(vlan_id), .ip_source(ip_source),
        .udp_offset(udp_offset), .payload_offset(payload_offset),
        .mismatch_count(mismatches), .pending_count(pending), .result_count(results)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // random output stall: mostly short bursts, now and then a long one
    always @(posedge clk)
    begin
        int r;
        if (rst_n)
        begin
            if (stall_left > 0)
                stall_left--;
            else
            begin
                r = $urandom_range(0, 99);
                out_stall <= ($urandom_range(0, 2) == 0);
                if (r < 80)
                    stall_left = $urandom_range(0, 3);
                else if (r < 95)
                    stall_left = $urandom_range(4, 12);
                else
                    stall_left = $urandom_range(20, 60);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0 || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic set_byte(input int idx, input logic [7:0] v);
        if (idx < frame_bytes.size())
            frame_bytes[idx] = v;
    endtask

    // random bytes with the ethertype chain and IPv4 fields laid over them
    task automatic build_frame(input int tags, input logic [15:0] etype,
                               input logic [7:0] ver_ihl, input logic [7:0] proto,
                               input int len);
        logic [15:0] nxt;
        int          ip;
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom));
        nxt = (tags > 0) ? ETH_TYPE_VLAN : etype;
        set_byte(12, nxt[15:8]);
        set_byte(13, nxt[7:0]);
        for (int t = 0; t < tags; t++)
        begin
            nxt = (t == tags - 1) ? etype : ETH_TYPE_VLAN;
            set_byte(ETH_HDR_BYTES + TAG_BYTES * t + 2, nxt[15:8]);
            set_byte(ETH_HDR_BYTES + TAG_BYTES * t + 3, nxt[7:0]);
        end
        ip = ETH_HDR_BYTES + TAG_BYTES * tags;
        set_byte(ip, ver_ihl);
        set_byte(ip + 9, proto);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    task automatic send_built(input int tags, input logic [15:0] etype,
                              input logic [7:0] ver_ihl, input logic [7:0] proto,
                              input int len);
        build_frame(tags, etype, ver_ihl, proto, len);
        send_frame();
    endtask

    initial
    begin
        int kind;
        int tags;
        int ip;
        int len;
        int r;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames: truncation at every header, tag limits, IP flags
        idle_mode = 0;
        send_built(0, 16'h0800, 8'h45, PROTO_UDP, 1);
        send_built(0, 16'h0800, 8'h45, PROTO_UDP, 14);
        send_built(0, 16'h0800, 8'h45, PROTO_UDP, 15);
        send_built(0, 16'h0800, 8'h45, PROTO_UDP, 34);
        send_built(0, 16'h0800, 8'h45, PROTO_UDP, 35);
        send_built(1, 16'h0800, 8'h45, PROTO_UDP, 15);
        send_built(1, 16'h0800, 8'h45, PROTO_UDP, 16);
        send_built(1, 16'h0800, 8'h45, PROTO_UDP, 18);
        send_built(2, 16'h0800, 8'h45, PROTO_UDP, 20);
        send_built(0, 16'h0800, 8'h45, PROTO_UDP, 58);
        send_built(0, 16'h0800, 8'h45, PROTO_UDP, 59);
        send_built(MAX_VLAN_TAGS_DEF, 16'h0800, 8'h45, PROTO_UDP, 75);
        send_built(MAX_VLAN_TAGS_DEF + 1, 16'h0800, 8'h45, PROTO_UDP, 60);
        send_built(MAX_VLAN_TAGS_DEF, ETH_TYPE_VLAN, 8'h45, PROTO_UDP, 40);
        send_built(0, 16'h0800, 8'h46, PROTO_IGMP, 80);
        send_built(1, 16'h0800, 8'h4F, 8'd6, 80);
        send_built(0, 16'h86DD, 8'h45, 8'd6, 70);
        build_frame(0, 16'h0000, 8'h00, 8'h00, 60);
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        send_frame();
        build_frame(0, 16'hFFFF, 8'hFF, 8'hFF, 60);
        foreach (frame_bytes[i]) frame_bytes[i] = 8'hFF;
        send_frame();

        // random frames, mostly well formed
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            idle_mode = $urandom_range(0, 3);
            kind      = $urandom_range(0, 9);
            r         = $urandom_range(0, 99);
            tags      = (r < 45) ? 0 : (r < 90) ? $urandom_range(1, MAX_VLAN_TAGS_DEF)
                                              : $urandom_range(MAX_VLAN_TAGS_DEF + 1, 6);
            r         = $urandom_range(0, 99);
            etype     = (r < 80) ? 16'h0800 : (r < 88) ? ETH_TYPE_VLAN : 16'($urandom);
            r         = $urandom_range(0, 99);
            ver_ihl   = (r < 75) ? 8'h45 : 8'($urandom);
            r         = $urandom_range(0, 99);
            proto     = (r < 70) ? PROTO_UDP : (r < 85) ? PROTO_IGMP : 8'($urandom);
            ip        = ETH_HDR_BYTES + TAG_BYTES * tags;
            if (kind <= 5)
            begin
                r   = $urandom_range(0, 9);
                len = ip + IP_HDR_BYTES + UDP_HDR_BYTES + APP_HEADER_BYTES_DEF;
                if (r < 7)
                    len = len + $urandom_range(1, 12);
                else if (r < 9)
                    len = len + $urandom_range(0, 1) - 1;
                send_built(tags, etype, ver_ihl, proto, len);
            end
            else if (kind <= 7)
                send_built(tags, etype, ver_ihl, proto, $urandom_range(1, ip + 45));
            else
                send_built(0, 16'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(1, 70));
        end

        // drain: let the last request through, then allow for the pipeline
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d frames: truncated, tagged, tag overflow, IGMP, long IHL, non-UDP,",
                 frames_sent);
        $display("all-zero, all-one and noise frames; %0d results compared", results);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
